// ----- design/sdspi_pkg.sv -----
// ============================================================================
// sdspi_pkg
// Shared phase codes, opcodes, command bytes and status codes of the SD card
// SPI-mode host sequencer.
// ============================================================================
package sdspi_pkg;

    localparam int DataBlockBytes = 512;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_PWR     = 5'd1,
        PH_C0_GAP  = 5'd2,
        PH_C8_GAP  = 5'd3,
        PH_C8_TAIL = 5'd4,
        PH_TO_C55  = 5'd5,
        PH_TO_A41  = 5'd6,
        PH_FRAME   = 5'd7,
        PH_POLL    = 5'd8,
        PH_TOKEN   = 5'd9,
        PH_RDATA   = 5'd10,
        PH_RCRC    = 5'd11,
        PH_WTOKEN  = 5'd12,
        PH_WDATA   = 5'd13,
        PH_WCRC    = 5'd14,
        PH_WRESP   = 5'd15,
        PH_BUSY    = 5'd16,
        PH_FINAL   = 5'd17
    } phase_t;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [2:0] REG_BLK_LOG2  = 3'd0;
    localparam logic [2:0] REG_CMD0      = 3'd1;
    localparam logic [2:0] REG_ACMD41    = 3'd2;
    localparam logic [2:0] REG_TOKEN_TO  = 3'd3;
    localparam logic [2:0] REG_RESP_POLL = 3'd4;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD8   = 8'h48;
    localparam logic [7:0] CMD17  = 8'h51;
    localparam logic [7:0] CMD24  = 8'h58;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] ACMD41 = 8'h69;

    localparam logic [7:0] CRC_CMD0 = 8'h95;
    localparam logic [7:0] CRC_CMD8 = 8'h87;
    localparam logic [7:0] FILL     = 8'hFF;
    localparam logic [7:0] TOKEN    = 8'hFE;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_IDLE_TO    = 3'd1;
    localparam logic [2:0] ST_INIT_TO    = 3'd2;
    localparam logic [2:0] ST_REJECTED   = 3'd3;
    localparam logic [2:0] ST_TOKEN_TO   = 3'd4;
    localparam logic [2:0] ST_WR_REJECT  = 3'd5;
    localparam logic [2:0] ST_BUSY_TO    = 3'd6;

    // card version codes
    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_BYTE    = 2'd1;
    localparam logic [1:0] VER_BLOCK   = 2'd2;

endpackage

// ----- design/sd_card_spi_host_sequencer.sv -----
// ============================================================================
// sd_card_spi_host_sequencer
// Host-side SD card sequencer for SPI mode: init, single block read/write.
// ============================================================================
// Usage: each input word is a start request (init, read, write) or the byte
// the card returned for the previous exchange. Each input word yields one
// output word: the next byte to shift out (tx_valid), chip-select level,
// write data consumption, read data, and done/status on the last word.
// The result is computed combinationally from the state and the input and
// captured in an output register at acceptance.
// Throughput: one word per cycle while the receiver keeps up; in_ready stays
// high while the output register is empty or being drained in the same cycle.
// A stalled receiver holds the output register, and in_ready drops until the
// held word is taken.
// Reset clears the sequencer to idle, card version unknown, and loads the
// configuration registers with their defaults.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must do this only while idle (not enforced).
// ============================================================================
module sd_card_spi_host_sequencer #(
    parameter int BLOCK_BYTES = sdspi_pkg::DataBlockBytes
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] block_number,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        chip_select_low,
    output logic        write_byte_taken,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [1:0]  card_version,
    output logic        busy_res
);
    import sdspi_pkg::*;

    localparam int CntW = $clog2(BLOCK_BYTES + 1) < 6 ? 6 : $clog2(BLOCK_BYTES + 1);

    // configuration
    logic [3:0]  blk_log2_reg;
    logic [15:0] cmd0_tries_reg, acmd41_tries_reg, token_to_reg;
    logic [7:0]  resp_polls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_log2_reg     <= 4'd9;
            cmd0_tries_reg   <= 16'd200;
            acmd41_tries_reg <= 16'd20000;
            token_to_reg     <= 16'd10000;
            resp_polls_reg   <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLK_LOG2:  blk_log2_reg     <= cfg_data[3:0];
                REG_CMD0:      cmd0_tries_reg   <= cfg_data;
                REG_ACMD41:    acmd41_tries_reg <= cfg_data;
                REG_TOKEN_TO:  token_to_reg     <= cfg_data;
                REG_RESP_POLL: resp_polls_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    phase_t          phase_reg, phase_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [15:0]     retry_reg, retry_next;
    logic [15:0]     poll_reg, poll_next;
    logic [47:0]     frame_reg, frame_next;
    logic            v2_reg, v2_next;
    logic [1:0]      gen_reg, gen_next;
    logic            cs_reg, cs_next;
    logic [2:0]      pend_reg, pend_next;
    logic            init_op_reg, init_op_next;
    logic [7:0]      last_reg, last_next;

    // output word
    logic [7:0] o_tx, o_rd;
    logic       o_valid, o_taken, o_rvalid, o_done;
    logic [2:0] o_status;

    logic accept;
    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    logic [15:0] cmd0_min, acmd_min, tok_min;
    logic [7:0]  resp_min;
    assign cmd0_min = (cmd0_tries_reg == 16'd0) ? 16'd1 : cmd0_tries_reg;
    assign acmd_min = (acmd41_tries_reg == 16'd0) ? 16'd1 : acmd41_tries_reg;
    assign tok_min  = (token_to_reg == 16'd0) ? 16'd1 : token_to_reg;
    assign resp_min = (resp_polls_reg == 8'd0) ? 8'd1 : resp_polls_reg;

    logic [31:0] shifted_addr;
    assign shifted_addr = block_number << blk_log2_reg;

    logic [7:0] frame_sel;
    logic [15:0] poll_dec, retry_dec;
    logic [CntW-1:0] cnt_dec;
    assign poll_dec  = poll_reg - 16'd1;
    assign retry_dec = retry_reg - 16'd1;
    assign cnt_dec   = cnt_reg - CntW'(1);

    always_comb
    begin
        case (cnt_reg[2:0])
            3'd1:    frame_sel = frame_reg[39:32];
            3'd2:    frame_sel = frame_reg[31:24];
            3'd3:    frame_sel = frame_reg[23:16];
            3'd4:    frame_sel = frame_reg[15:8];
            3'd5:    frame_sel = frame_reg[7:0];
            default: frame_sel = frame_reg[47:40];
        endcase
    end

    // next-state logic for one word
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        retry_next   = retry_reg;
        poll_next    = poll_reg;
        frame_next   = frame_reg;
        v2_next      = v2_reg;
        gen_next     = gen_reg;
        cs_next      = cs_reg;
        pend_next    = pend_reg;
        init_op_next = init_op_reg;
        last_next    = last_reg;
        o_tx = 8'd0; o_valid = 1'b0; o_taken = 1'b0; o_rd = 8'd0;
        o_rvalid = 1'b0; o_done = 1'b0; o_status = ST_OK;

        if (phase_reg != PH_IDLE)
        begin
            if (opcode != OP_BYTE)
            begin
                o_tx = last_reg; o_valid = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_PWR, PH_C0_GAP, PH_C8_GAP, PH_C8_TAIL, PH_TO_C55, PH_TO_A41:
                    begin
                        cnt_next = cnt_dec;
                        o_tx = FILL; o_valid = 1'b1;
                        if (cnt_dec == '0)
                        begin
                            case (phase_reg)
                                PH_PWR:
                                begin
                                    phase_next = PH_C0_GAP; cnt_next = CntW'(8);
                                end
                                PH_C0_GAP:
                                begin
                                    frame_next = {CMD0, 32'd0, CRC_CMD0};
                                    phase_next = PH_FRAME; cnt_next = CntW'(1);
                                    cs_next = 1'b1; o_tx = CMD0;
                                end
                                PH_C8_GAP:
                                begin
                                    frame_next = {CMD8, 32'h000001AA, CRC_CMD8};
                                    phase_next = PH_FRAME; cnt_next = CntW'(1);
                                    cs_next = 1'b1; o_tx = CMD8;
                                end
                                PH_C8_TAIL:
                                begin
                                    cs_next = 1'b0; phase_next = PH_TO_C55;
                                    cnt_next = CntW'(8);
                                end
                                PH_TO_C55:
                                begin
                                    frame_next = {CMD55, 32'd0, FILL};
                                    phase_next = PH_FRAME; cnt_next = CntW'(1);
                                    cs_next = 1'b1; o_tx = CMD55;
                                end
                                default:
                                begin
                                    frame_next = {ACMD41, (v2_reg ? 32'h40000000 : 32'd0),
                                                  FILL};
                                    phase_next = PH_FRAME; cnt_next = CntW'(1);
                                    cs_next = 1'b1; o_tx = ACMD41;
                                end
                            endcase
                        end
                    end
                    PH_FRAME:
                    begin
                        o_valid = 1'b1;
                        if (cnt_reg < CntW'(6))
                        begin
                            o_tx = frame_sel; cnt_next = cnt_reg + CntW'(1);
                        end
                        else
                        begin
                            o_tx = FILL; poll_next = {8'd0, resp_min};
                            phase_next = PH_POLL; cnt_next = '0;
                        end
                    end
                    PH_POLL:
                    begin
                        poll_next = poll_dec;
                        o_valid = 1'b1; o_tx = FILL;
                        if (!rx_byte[7] || poll_dec == 16'd0)
                        begin
                            cnt_next = CntW'(8);
                            if (frame_reg[47:40] == CMD0)
                            begin
                                if (rx_byte == 8'h01)
                                    phase_next = PH_C8_GAP;
                                else
                                begin
                                    retry_next = retry_dec;
                                    if (retry_dec == 16'd0)
                                    begin
                                        pend_next = ST_IDLE_TO; cs_next = 1'b0;
                                        phase_next = PH_FINAL;
                                    end
                                    else
                                        phase_next = PH_C0_GAP;
                                end
                            end
                            else if (frame_reg[47:40] == CMD8)
                            begin
                                retry_next = acmd_min;
                                if (rx_byte == 8'h01)
                                begin
                                    v2_next = 1'b1; phase_next = PH_C8_TAIL;
                                    cnt_next = CntW'(4);
                                end
                                else
                                begin
                                    cs_next = 1'b0; phase_next = PH_TO_C55;
                                end
                            end
                            else if (frame_reg[47:40] == CMD55)
                            begin
                                cs_next = 1'b0; phase_next = PH_TO_A41;
                                cnt_next = CntW'(16);
                            end
                            else if (frame_reg[47:40] == ACMD41)
                            begin
                                if (rx_byte == 8'h00)
                                begin
                                    pend_next = ST_OK; cs_next = 1'b0;
                                    phase_next = PH_FINAL; cnt_next = CntW'(24);
                                end
                                else
                                begin
                                    retry_next = retry_dec;
                                    cs_next = 1'b0;
                                    if (retry_dec == 16'd0)
                                    begin
                                        pend_next = ST_INIT_TO; phase_next = PH_FINAL;
                                        cnt_next = CntW'(16);
                                    end
                                    else
                                        phase_next = PH_TO_C55;
                                end
                            end
                            else if (frame_reg[47:40] == CMD17 && rx_byte == 8'h00)
                            begin
                                poll_next = tok_min; phase_next = PH_TOKEN;
                                cnt_next = '0;
                            end
                            else if (frame_reg[47:40] == CMD24 && rx_byte == 8'h00)
                            begin
                                phase_next = PH_WTOKEN; o_tx = TOKEN;
                                cnt_next = cnt_reg;
                            end
                            else
                            begin
                                pend_next = ST_REJECTED; cs_next = 1'b0;
                                phase_next = PH_FINAL;
                            end
                        end
                    end
                    PH_TOKEN:
                    begin
                        o_valid = 1'b1; o_tx = FILL;
                        if (rx_byte == TOKEN)
                        begin
                            phase_next = PH_RDATA; cnt_next = CntW'(BLOCK_BYTES);
                        end
                        else
                        begin
                            poll_next = poll_dec;
                            if (poll_dec == 16'd0)
                            begin
                                pend_next = ST_TOKEN_TO; cs_next = 1'b0;
                                phase_next = PH_FINAL; cnt_next = CntW'(8);
                            end
                        end
                    end
                    PH_RDATA:
                    begin
                        o_rd = rx_byte; o_rvalid = 1'b1;
                        o_valid = 1'b1; o_tx = FILL;
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            phase_next = PH_RCRC; cnt_next = CntW'(2);
                        end
                    end
                    PH_RCRC:
                    begin
                        o_valid = 1'b1; o_tx = FILL;
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            pend_next = ST_OK; cs_next = 1'b0;
                            phase_next = PH_FINAL; cnt_next = CntW'(8);
                        end
                    end
                    PH_WTOKEN:
                    begin
                        phase_next = PH_WDATA; cnt_next = CntW'(BLOCK_BYTES - 1);
                        o_valid = 1'b1; o_tx = write_byte; o_taken = 1'b1;
                    end
                    PH_WDATA:
                    begin
                        o_valid = 1'b1;
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_dec; o_tx = write_byte; o_taken = 1'b1;
                        end
                        else
                        begin
                            o_tx = FILL; phase_next = PH_WCRC; cnt_next = CntW'(1);
                        end
                    end
                    PH_WCRC:
                    begin
                        o_valid = 1'b1; o_tx = FILL;
                        if (cnt_reg != '0)
                            cnt_next = cnt_dec;
                        else
                            phase_next = PH_WRESP;
                    end
                    PH_WRESP:
                    begin
                        o_valid = 1'b1; o_tx = FILL;
                        if (rx_byte[4:0] != 5'h05)
                        begin
                            pend_next = ST_WR_REJECT; cs_next = 1'b0;
                            phase_next = PH_FINAL; cnt_next = CntW'(8);
                        end
                        else
                        begin
                            poll_next = tok_min; phase_next = PH_BUSY; cnt_next = '0;
                        end
                    end
                    PH_BUSY:
                    begin
                        o_valid = 1'b1; o_tx = FILL;
                        if (rx_byte != 8'd0)
                        begin
                            pend_next = ST_OK; cs_next = 1'b0;
                            phase_next = PH_FINAL; cnt_next = CntW'(8);
                        end
                        else
                        begin
                            poll_next = poll_dec;
                            if (poll_dec == 16'd0)
                            begin
                                pend_next = ST_BUSY_TO; cs_next = 1'b0;
                                phase_next = PH_FINAL; cnt_next = CntW'(8);
                            end
                        end
                    end
                    PH_FINAL:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_dec != '0)
                        begin
                            o_valid = 1'b1; o_tx = FILL;
                        end
                        else
                        begin
                            o_done = 1'b1; o_status = pend_reg;
                            if (init_op_reg)
                                gen_next = (pend_reg == ST_OK) ?
                                           (v2_reg ? VER_BLOCK : VER_BYTE) : VER_UNKNOWN;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
        else if (opcode == OP_INIT)
        begin
            init_op_next = 1'b1; v2_next = 1'b0; cs_next = 1'b0;
            retry_next = cmd0_min; phase_next = PH_PWR; cnt_next = CntW'(32);
            o_valid = 1'b1; o_tx = FILL;
        end
        else if (opcode != OP_BYTE)
        begin
            init_op_next = 1'b0;
            frame_next = {(opcode == OP_READ ? CMD17 : CMD24),
                          (gen_reg == VER_BYTE ? shifted_addr : block_number), FILL};
            cs_next = 1'b1; phase_next = PH_FRAME; cnt_next = CntW'(1);
            o_valid = 1'b1; o_tx = (opcode == OP_READ) ? CMD17 : CMD24;
        end

        if (o_valid)
            last_next = o_tx;
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            retry_reg   <= '0;
            poll_reg    <= '0;
            frame_reg   <= '0;
            v2_reg      <= 1'b0;
            gen_reg     <= VER_UNKNOWN;
            cs_reg      <= 1'b0;
            pend_reg    <= ST_OK;
            init_op_reg <= 1'b0;
            last_reg    <= FILL;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                cnt_reg     <= cnt_next;
                retry_reg   <= retry_next;
                poll_reg    <= poll_next;
                frame_reg   <= frame_next;
                v2_reg      <= v2_next;
                gen_reg     <= gen_next;
                cs_reg      <= cs_next;
                pend_reg    <= pend_next;
                init_op_reg <= init_op_next;
                last_reg    <= last_next;
                out_valid   <= 1'b1;
            end
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_byte          <= o_tx;
            tx_valid         <= o_valid;
            chip_select_low  <= cs_next;
            write_byte_taken <= o_taken;
            read_byte        <= o_rd;
            read_valid       <= o_rvalid;
            done_res         <= o_done;
            status           <= o_status;
            card_version     <= gen_next;
            busy_res         <= (phase_next != PH_IDLE);
        end
    end

`ifndef SYNTHESIS
    // a held result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted over a held result");

    // done only when the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && o_done |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    // chip select is released before the closing clocks
    a_final_cs: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FINAL |-> !cs_reg)
        else $error("card selected during closing clocks");
`endif

endmodule

// ----- bench/tb_sd_card_spi_host_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_sd_card_spi_host_sequencer
// Self-checking bench for the SD card SPI-mode host sequencer. A simple card
// model answers each byte the block asks for. A cycle-free predictor works
// out every output word, and a checker compares each word taken from the
// block against it. Configuration is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_sequencer;
    import sdspi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] tx;
        logic       txv;
        logic       cs;
        logic       taken;
        logic [7:0] rd;
        logic       rv;
        logic       done;
        logic [2:0] st;
        logic [1:0] ver;
        logic       busy;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_BLK_LOG2;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = OP_BYTE;
    logic [31:0] block_number = 32'd0;
    logic [7:0]  rx_byte = 8'd0;
    logic [7:0]  write_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select_low;
    logic        write_byte_taken;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [1:0]  card_version;
    logic        busy_res;

    sd_card_spi_host_sequencer dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicted sequencer state and its copy of the registers
    phase_t      pm_phase;
    logic [15:0] pm_count, pm_retry, pm_poll;
    logic [47:0] pm_frame;
    logic        pm_v2, pm_cs;
    logic [1:0]  pm_gen, pm_op;
    logic [2:0]  pm_pend;
    logic [7:0]  pm_last;
    logic [3:0]  cf_blk;
    logic [15:0] cf_cmd0, cf_acmd, cf_tok;
    logic [7:0]  cf_resp;
    word_t       pw;

    word_t expected_words[$];
    int errors = 0;
    int items_sent = 0;
    int words_checked = 0;
    int ops_done[8];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int good_pct = 100;
    int noise_pct = 0;
    int cmd8_mode = 0;
    int reject_data = 0;
    int quiet_cycles = 0;

    function automatic logic [15:0] one_min(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void emit(logic [7:0] b);
        pw.tx = b;
        pw.txv = 1'b1;
        pm_last = b;
    endfunction

    function automatic void run_phase(phase_t ph, logic [15:0] n);
        pm_phase = ph;
        pm_count = n;
        emit(FILL);
    endfunction

    function automatic void finish_with(logic [2:0] st, logic [15:0] n);
        pm_pend = st;
        pm_cs = 1'b0;
        run_phase(PH_FINAL, n);
    endfunction

    function automatic logic [7:0] frame_at(logic [15:0] k);
        logic [47:0] sh;
        sh = pm_frame >> ((5 - (k % 6)) * 8);
        return sh[7:0];
    endfunction

    function automatic void send_frame(logic [7:0] cmd, logic [31:0] arg, logic [7:0] crc);
        pm_frame = {cmd, arg, crc};
        pm_cs = 1'b1;
        pm_phase = PH_FRAME;
        pm_count = 16'd1;
        emit(cmd);
    endfunction

    // Decision once a command response (or the last poll) is in
    function automatic void take_response(logic [7:0] r);
        logic [7:0] cmd;
        cmd = frame_at(16'd0);
        if (cmd == CMD0) begin
            if (r == 8'h01) run_phase(PH_C8_GAP, 16'd8);
            else begin
                pm_retry--;
                if (pm_retry == 0) finish_with(ST_IDLE_TO, 16'd8);
                else run_phase(PH_C0_GAP, 16'd8);
            end
        end else if (cmd == CMD8) begin
            pm_retry = one_min(cf_acmd);
            if (r == 8'h01) begin
                pm_v2 = 1'b1;
                run_phase(PH_C8_TAIL, 16'd4);
            end else begin
                pm_cs = 1'b0;
                run_phase(PH_TO_C55, 16'd8);
            end
        end else if (cmd == CMD55) begin
            pm_cs = 1'b0;
            run_phase(PH_TO_A41, 16'd16);
        end else if (cmd == ACMD41) begin
            if (r == 8'h00) finish_with(ST_OK, 16'd24);
            else begin
                pm_retry--;
                if (pm_retry == 0) finish_with(ST_INIT_TO, 16'd16);
                else begin
                    pm_cs = 1'b0;
                    run_phase(PH_TO_C55, 16'd8);
                end
            end
        end else if (cmd == CMD17 && r == 8'h00) begin
            pm_poll = one_min(cf_tok);
            run_phase(PH_TOKEN, 16'd0);
        end else if (cmd == CMD24 && r == 8'h00) begin
            pm_phase = PH_WTOKEN;
            emit(TOKEN);
        end else
            finish_with(ST_REJECTED, 16'd8);
    endfunction

    // One exchanged byte while an operation runs
    function automatic void take_byte(logic [7:0] rx, logic [7:0] wb);
        case (pm_phase)
            PH_PWR, PH_C0_GAP, PH_C8_GAP, PH_C8_TAIL, PH_TO_C55, PH_TO_A41:
            begin
                pm_count--;
                if (pm_count != 0) emit(FILL);
                else if (pm_phase == PH_PWR) run_phase(PH_C0_GAP, 16'd8);
                else if (pm_phase == PH_C0_GAP) send_frame(CMD0, 32'd0, CRC_CMD0);
                else if (pm_phase == PH_C8_GAP) send_frame(CMD8, 32'h000001AA, CRC_CMD8);
                else if (pm_phase == PH_C8_TAIL) begin
                    pm_cs = 1'b0;
                    run_phase(PH_TO_C55, 16'd8);
                end else if (pm_phase == PH_TO_C55) send_frame(CMD55, 32'd0, FILL);
                else send_frame(ACMD41, pm_v2 ? 32'h40000000 : 32'd0, FILL);
            end
            PH_FRAME:
                if (pm_count < 6) begin
                    emit(frame_at(pm_count));
                    pm_count++;
                end else begin
                    pm_poll = one_min({8'd0, cf_resp});
                    run_phase(PH_POLL, 16'd0);
                end
            PH_POLL:
            begin
                pm_poll--;
                if (!rx[7] || pm_poll == 0) take_response(rx);
                else emit(FILL);
            end
            PH_TOKEN:
                if (rx == TOKEN) run_phase(PH_RDATA, 16'(DataBlockBytes));
                else begin
                    pm_poll--;
                    if (pm_poll == 0) finish_with(ST_TOKEN_TO, 16'd8);
                    else emit(FILL);
                end
            PH_RDATA:
            begin
                pw.rd = rx;
                pw.rv = 1'b1;
                pm_count--;
                if (pm_count == 0) run_phase(PH_RCRC, 16'd2);
                else emit(FILL);
            end
            PH_RCRC:
            begin
                pm_count--;
                if (pm_count == 0) finish_with(ST_OK, 16'd8);
                else emit(FILL);
            end
            PH_WTOKEN:
            begin
                pm_phase = PH_WDATA;
                pm_count = 16'(DataBlockBytes - 1);
                emit(wb);
                pw.taken = 1'b1;
            end
            PH_WDATA:
                if (pm_count > 0) begin
                    pm_count--;
                    emit(wb);
                    pw.taken = 1'b1;
                end else run_phase(PH_WCRC, 16'd1);
            PH_WCRC:
                if (pm_count > 0) begin
                    pm_count--;
                    emit(FILL);
                end else run_phase(PH_WRESP, 16'd0);
            PH_WRESP:
                if (rx[4:0] != 5'h05) finish_with(ST_WR_REJECT, 16'd8);
                else begin
                    pm_poll = one_min(cf_tok);
                    run_phase(PH_BUSY, 16'd0);
                end
            PH_BUSY:
                if (rx != 8'd0) finish_with(ST_OK, 16'd8);
                else begin
                    pm_poll--;
                    if (pm_poll == 0) finish_with(ST_BUSY_TO, 16'd8);
                    else emit(FILL);
                end
            PH_FINAL:
            begin
                pm_count--;
                if (pm_count != 0) emit(FILL);
                else begin
                    pw.done = 1'b1;
                    pw.st = pm_pend;
                    ops_done[pm_pend]++;
                    if (pm_op == OP_INIT)
                        pm_gen = (pm_pend == ST_OK) ? (pm_v2 ? VER_BLOCK : VER_BYTE)
                                                    : VER_UNKNOWN;
                    pm_phase = PH_IDLE;
                end
            end
            default: pm_phase = PH_IDLE;
        endcase
    endfunction

    function automatic word_t predict_word(logic [1:0] opc, logic [31:0] blk,
                                           logic [7:0] rx, logic [7:0] wb);
        logic [31:0] addr;
        pw = '0;
        if (pm_phase != PH_IDLE) begin
            if (opc == OP_BYTE) take_byte(rx, wb);
            else emit(pm_last);
        end else if (opc == OP_INIT) begin
            pm_op = OP_INIT;
            pm_v2 = 1'b0;
            pm_cs = 1'b0;
            pm_retry = one_min(cf_cmd0);
            run_phase(PH_PWR, 16'd32);
        end else if (opc != OP_BYTE) begin
            addr = (pm_gen == VER_BYTE) ? (blk << cf_blk) : blk;
            pm_op = opc;
            send_frame((opc == OP_READ) ? CMD17 : CMD24, addr, FILL);
        end
        if (!pw.txv) pw.tx = 8'd0;
        pw.cs = pm_cs;
        pw.ver = pm_gen;
        pw.busy = (pm_phase != PH_IDLE);
        return pw;
    endfunction

    // Card side: picks the byte returned for the exchange just asked for
    function automatic logic [7:0] card_answer();
        logic [7:0] r;
        logic       good;
        r = 8'($urandom_range(255));
        // illegal-command answer keeps data commands short when asked to
        if (reject_data != 0 && pm_phase == PH_POLL &&
            (frame_at(16'd0) == CMD17 || frame_at(16'd0) == CMD24))
            return 8'h04;
        good = ($urandom_range(99) < good_pct);
        if (!good) return r;
        case (pm_phase)
            PH_POLL:
                case (frame_at(16'd0))
                    CMD0:   r = 8'h01;
                    CMD8:   r = (cmd8_mode == 1 || (cmd8_mode == 0 && r[0])) ? 8'h01 : 8'h05;
                    CMD55:  r = 8'h01;
                    ACMD41: r = ($urandom_range(2) != 0) ? 8'h00 : 8'h01;
                    default: r = 8'h00;
                endcase
            PH_TOKEN: r = ($urandom_range(3) == 0) ? TOKEN : FILL;
            PH_WRESP: r = {r[7:5], 5'h05};
            PH_BUSY:  r = ($urandom_range(2) != 0) ? 8'h00 : (r | 8'h01);
            default: ;
        endcase
        return r;
    endfunction

    // Drive one word and wait for it to be taken
    task automatic send_word(logic [1:0] opc, logic [31:0] blk, logic [7:0] rx,
                             logic [7:0] wb);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= opc;
        block_number <= blk;
        rx_byte <= rx;
        write_byte <= wb;
        do @(posedge clk); while (!in_ready);
        expected_words.push_back(predict_word(opc, blk, rx, wb));
        items_sent++;
    endtask

    // Start one operation and feed card bytes until it completes
    task automatic run_op(logic [1:0] opc, logic [31:0] blk);
        logic [1:0] o;
        send_word(opc, blk, 8'($urandom_range(255)), 8'($urandom_range(255)));
        while (pm_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                o = 2'($urandom_range(3));
                send_word(o, $urandom(), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            end else
                send_word(OP_BYTE, $urandom(), card_answer(), 8'($urandom_range(255)));
        end
    endtask

    // Hold off the sender until every expected word is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BLK_LOG2:  cf_blk = val[3:0];
            REG_CMD0:      cf_cmd0 = val;
            REG_ACMD41:    cf_acmd = val;
            REG_TOKEN_TO:  cf_tok = val;
            REG_RESP_POLL: cf_resp = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] blk, logic [15:0] c0, logic [15:0] a41,
                            logic [15:0] tok, logic [15:0] resp);
        drain();
        write_reg(REG_BLK_LOG2, blk);
        write_reg(REG_CMD0, c0);
        write_reg(REG_ACMD41, a41);
        write_reg(REG_TOKEN_TO, tok);
        write_reg(REG_RESP_POLL, resp);
    endtask

    // Bytes and starts with nothing running, and access before any init
    task automatic test_idle_cases();
        good_pct = 100;
        send_word(OP_BYTE, 32'hFFFFFFFF, 8'hFF, 8'hFF);
        send_word(OP_BYTE, 32'd0, 8'h00, 8'h00);
        reject_data = 1;
        run_op(OP_READ, 32'hFFFFFFFF);
        run_op(OP_WRITE, 32'd0);
        reject_data = 0;
    endtask

    // Init on a block-addressed card, then a full block read
    task automatic test_init_read();
        good_pct = 100;
        cmd8_mode = 1;
        run_op(OP_INIT, 32'd0);
        run_op(OP_READ, 32'h89ABCDEF);
        cmd8_mode = 0;
    endtask

    // Init on a byte-addressed card, then a full block write with noise
    task automatic test_init_write();
        good_pct = 100;
        cmd8_mode = 2;
        noise_pct = 5;
        run_op(OP_INIT, 32'd0);
        run_op(OP_WRITE, 32'h00ABCDEF);
        noise_pct = 0;
        cmd8_mode = 0;
    endtask

    // Tight limits, zero counts, the widest shift and the largest counts
    task automatic test_limits();
        set_regs(16'd15, 16'd1, 16'd1, 16'd1, 16'd1);
        good_pct = 100;
        cmd8_mode = 2;
        reject_data = 1;
        run_op(OP_INIT, 32'd0);
        run_op(OP_READ, 32'hFFFFFFFF);
        run_op(OP_WRITE, 32'h00000001);
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        good_pct = 30;
        cmd8_mode = 0;
        run_op(OP_INIT, 32'd0);
        reject_data = 0;
        repeat (2) run_op(OP_READ, $urandom());
        reject_data = 1;
        run_op(OP_WRITE, $urandom());
        set_regs(16'd11, 16'd65535, 16'd65535, 16'd65535, 16'd255);
        good_pct = 90;
        run_op(OP_READ, $urandom());
        run_op(OP_WRITE, $urandom());
        reject_data = 0;
    endtask

    // Short random operations plus noise until the item budget is used
    task automatic test_random(int target);
        int pick;
        reject_data = 1;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            good_pct = ($urandom_range(3) == 0) ? 40 : 95;
            noise_pct = ($urandom_range(3) == 0) ? 5 : 0;
            if (pick < 60) run_op(OP_INIT, $urandom());
            else if (pick < 78) run_op(OP_READ, $urandom());
            else if (pick < 95) run_op(OP_WRITE, $urandom());
            else send_word(OP_BYTE, $urandom(), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
        end
        noise_pct = 0;
        reject_data = 0;
    endtask

    // Receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, exp, act);
            errors++;
        end
    endfunction

    // Compare each word taken with the oldest prediction
    always @(posedge clk)
    begin
        word_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: tx %0h", $realtime, tx_byte);
                errors++;
            end else begin
                e = expected_words.pop_front();
                check_field("tx_byte", e.tx, tx_byte);
                check_field("tx_valid", e.txv, tx_valid);
                check_field("chip_select_low", e.cs, chip_select_low);
                check_field("write_byte_taken", e.taken, write_byte_taken);
                check_field("read_byte", e.rd, read_byte);
                check_field("read_valid", e.rv, read_valid);
                check_field("done_res", e.done, done_res);
                check_field("status", e.st, status);
                check_field("card_version", e.ver, card_version);
                check_field("busy_res", e.busy, busy_res);
                words_checked++;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("%0t timeout with %0d words outstanding", $realtime,
                     expected_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        pm_phase = PH_IDLE;
        pm_count = 16'd0; pm_retry = 16'd0; pm_poll = 16'd0; pm_frame = '0;
        pm_v2 = 1'b0; pm_cs = 1'b0; pm_gen = VER_UNKNOWN; pm_op = OP_BYTE;
        pm_pend = ST_OK; pm_last = FILL;
        cf_blk = 4'd9; cf_cmd0 = 16'd200; cf_acmd = 16'd20000;
        cf_tok = 16'd10000; cf_resp = 8'd10;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 45;
        test_idle_cases();
        test_init_read();

        send_idle_pct = 45;
        recv_idle_pct = 21;
        test_init_write();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_limits();
        set_regs(16'($urandom_range(9, 11)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 64)),
                 16'($urandom_range(1, 8)));
        test_random(1650);

        drain();
        repeat (5) @(posedge clk);
        $display("%0d words sent, %0d results checked", items_sent, words_checked);
        $display("finished ops: ok %0d, idle to %0d, init to %0d, rejected %0d,",
                 ops_done[0], ops_done[1], ops_done[2], ops_done[3]);
        $display("  token to %0d, wr rej %0d, busy to %0d",
                 ops_done[4], ops_done[5], ops_done[6]);
        if (errors == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
